>>> rtl/dlt_pkg.sv
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types, codes and the lock mode compatibility function.
// ----------------------------------------------------------------------------
`default_nettype none

package dlt_pkg;

  localparam int DEF_ENTRIES = 16;

  localparam logic [1:0] KIND_REQUEST = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_CONVERT = 2'd2;
  localparam logic [1:0] KIND_PURGE   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_QUEUED   = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_DENIED   = 3'd3;
  localparam logic [2:0] ST_WOULDBLK = 3'd4;
  localparam logic [2:0] ST_FULL     = 3'd5;
  localparam logic [2:0] ST_NOTFOUND = 3'd6;
  localparam logic [2:0] ST_INVALID  = 3'd7;

  localparam logic [1:0] ES_WAITING    = 2'd0;
  localparam logic [1:0] ES_GRANTED    = 2'd1;
  localparam logic [1:0] ES_CONVERTING = 2'd2;
  localparam logic [1:0] ES_BLOCKED    = 2'd3;

  localparam logic [2:0] MODE_LIMIT = 3'd6;

  // row is the held mode, bit is the requested mode
  localparam logic [5:0] COMPAT_ROWS [6] = '{
    6'b111111, 6'b011111, 6'b000111, 6'b001011, 6'b000011, 6'b000001
  };

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_APPLY, S_PSEL, S_PCHK, S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic main_step;
    logic apply;
    logic sel_step;
    logic chk_step;
    logic chk_done;
  } cmd_t;

  typedef struct packed {
    logic idx_last;
    logic need_promote;
    logic sel_found;
  } sts_t;

  function automatic logic compat(input logic [2:0] held, input logic [2:0] req);
    logic r;
    r = 1'b0;
    if (held < MODE_LIMIT && req < MODE_LIMIT) r = COMPAT_ROWS[held][req];
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/dlt_datapath.sv
// ----------------------------------------------------------------------------
// dlt_datapath
// Lock table, scan index, pass accumulators and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dlt_datapath #(
  parameter int TABLE_ENTRIES = dlt_pkg::DEF_ENTRIES
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire dlt_pkg::cmd_t cmd,
  output dlt_pkg::sts_t      sts,
  input  wire logic [1:0]    kind,
  input  wire logic [31:0]   volume,
  input  wire logic [63:0]   inode,
  input  wire logic [63:0]   offset,
  input  wire logic [31:0]   alloc_group,
  input  wire logic [7:0]    res_type,
  input  wire logic [7:0]    node,
  input  wire logic [2:0]    mode,
  input  wire logic          noqueue,
  input  wire logic          trylock,
  output logic [2:0]         res_status,
  output logic [4:0]         res_purged,
  output logic [4:0]         res_promoted
);
  import dlt_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  logic [TABLE_ENTRIES-1:0] ent_valid;
  logic [31:0] ent_vol   [TABLE_ENTRIES];
  logic [63:0] ent_ino   [TABLE_ENTRIES];
  logic [63:0] ent_off   [TABLE_ENTRIES];
  logic [31:0] ent_grp   [TABLE_ENTRIES];
  logic [7:0]  ent_type  [TABLE_ENTRIES];
  logic [7:0]  ent_owner [TABLE_ENTRIES];
  logic [2:0]  ent_mode  [TABLE_ENTRIES];
  logic [1:0]  ent_st    [TABLE_ENTRIES];
  logic [15:0] ent_age   [TABLE_ENTRIES];
  logic [15:0] counter;
  logic [TABLE_ENTRIES-1:0] done;

  logic [1:0]  q_kind;
  logic [31:0] q_vol, q_grp;
  logic [63:0] q_ino, q_off;
  logic [7:0]  q_type, q_node;
  logic [2:0]  q_mode;
  logic        q_noq, q_try;

  logic [IW-1:0] idx;
  logic          exist, inc_all, inc_oth;
  logic          fr_found, r1_found, r2_found, cv_found;
  logic [IW-1:0] fr_idx, r1_idx, r2_idx, cv_idx;
  logic [15:0]   r1_key, r2_key, cv_key;
  logic [2:0]    cv_mode;
  logic [CW-1:0] pur_cnt, pro_cnt;
  logic          p_all, p_block;

  logic          w_found;
  logic [IW-1:0] w_idx;
  logic [15:0]   w_key;
  logic [31:0]   w_vol, w_grp;
  logic [63:0]   w_ino, w_off;
  logic [7:0]    w_type, w_owner;
  logic [2:0]    w_mode;
  logic          fail;

  logic          v_i, same_q, same_w, own_i, cand, hold_hit;
  logic [15:0]   key_i;
  logic          inv, need_p, rel_found;
  logic [IW-1:0] rel_idx;

  always_comb begin
    v_i    = ent_valid[idx];
    key_i  = 16'(counter - 16'd1 - ent_age[idx]);
    same_q = ent_vol[idx] == q_vol && ent_ino[idx] == q_ino && ent_off[idx] == q_off &&
             ent_grp[idx] == q_grp && ent_type[idx] == q_type;
    same_w = ent_vol[idx] == w_vol && ent_ino[idx] == w_ino && ent_off[idx] == w_off &&
             ent_grp[idx] == w_grp && ent_type[idx] == w_type;
    own_i  = ent_owner[idx] == q_node;
    cand   = v_i && (p_all || same_q) && !done[idx] &&
             (ent_st[idx] == ES_WAITING || ent_st[idx] == ES_BLOCKED);
    hold_hit = v_i && same_w && ent_st[idx] == ES_GRANTED && ent_owner[idx] != w_owner &&
               !compat(ent_mode[idx], w_mode);
    inv       = q_mode >= MODE_LIMIT;
    rel_found = r1_found || r2_found;
    rel_idx   = r1_found ? r1_idx : r2_idx;
    need_p = 1'b0;
    case (q_kind)
      KIND_RELEASE: need_p = rel_found;
      KIND_CONVERT: need_p = !inv && cv_found && q_mode <= cv_mode;
      KIND_PURGE:   need_p = 1'b1;
      default:      need_p = 1'b0;
    endcase
    sts.idx_last     = idx == IW'(TABLE_ENTRIES - 1);
    sts.need_promote = need_p;
    sts.sel_found    = w_found || cand;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_kind <= kind;
      q_vol  <= volume;
      q_ino  <= inode;
      q_off  <= offset;
      q_grp  <= alloc_group;
      q_type <= res_type;
      q_node <= node;
      q_mode <= mode;
      q_noq  <= noqueue;
      q_try  <= trylock;
    end
    if (cmd.idx_clr || ((cmd.main_step || cmd.sel_step || cmd.chk_step) && sts.idx_last)) begin
      idx <= '0;
    end else if (cmd.main_step || cmd.sel_step || cmd.chk_step) begin
      idx <= idx + 1'b1;
    end
    if (cmd.sel_step && cand && (!w_found || key_i < w_key)) begin
      w_idx   <= idx;
      w_key   <= key_i;
      w_vol   <= ent_vol[idx];
      w_ino   <= ent_ino[idx];
      w_off   <= ent_off[idx];
      w_grp   <= ent_grp[idx];
      w_type  <= ent_type[idx];
      w_owner <= ent_owner[idx];
      w_mode  <= ent_mode[idx];
    end
    if (cmd.main_step) begin
      if (v_i && same_q && own_i && (ent_st[idx] == ES_GRANTED ||
          ent_st[idx] == ES_CONVERTING) && (!r1_found || key_i < r1_key)) begin
        r1_idx <= idx;
        r1_key <= key_i;
      end
      if (v_i && same_q && own_i && (!r2_found || key_i < r2_key)) begin
        r2_idx <= idx;
        r2_key <= key_i;
      end
      if (v_i && same_q && own_i && ent_st[idx] == ES_GRANTED &&
          (!cv_found || key_i < cv_key)) begin
        cv_idx  <= idx;
        cv_key  <= key_i;
        cv_mode <= ent_mode[idx];
      end
      if (!v_i && !fr_found) fr_idx <= idx;
    end
    if (cmd.apply) begin
      p_all   <= q_kind == KIND_PURGE;
      p_block <= q_kind == KIND_RELEASE;
      res_status <= ST_OK;
      case (q_kind)
        KIND_REQUEST: begin
          if (inv) res_status <= ST_INVALID;
          else if (exist) res_status <= ST_EXISTS;
          else if (inc_all && q_noq) res_status <= ST_DENIED;
          else if (inc_all && q_try) res_status <= ST_WOULDBLK;
          else if (!fr_found) res_status <= ST_FULL;
          else begin
            ent_vol[fr_idx]   <= q_vol;
            ent_ino[fr_idx]   <= q_ino;
            ent_off[fr_idx]   <= q_off;
            ent_grp[fr_idx]   <= q_grp;
            ent_type[fr_idx]  <= q_type;
            ent_owner[fr_idx] <= q_node;
            ent_mode[fr_idx]  <= q_mode;
            ent_st[fr_idx]    <= inc_all ? ES_WAITING : ES_GRANTED;
            ent_age[fr_idx]   <= counter;
            res_status        <= inc_all ? ST_QUEUED : ST_OK;
          end
        end
        KIND_RELEASE: begin
          if (!rel_found) res_status <= ST_NOTFOUND;
        end
        KIND_CONVERT: begin
          if (inv) res_status <= ST_INVALID;
          else if (!cv_found) res_status <= ST_NOTFOUND;
          else begin
            ent_mode[cv_idx] <= q_mode;
            if (q_mode > cv_mode && inc_oth) begin
              ent_st[cv_idx] <= ES_CONVERTING;
              res_status     <= ST_QUEUED;
            end
          end
        end
        default: res_status <= ST_OK;
      endcase
    end
    if (cmd.chk_done) begin
      if (!(fail || hold_hit)) ent_st[w_idx] <= ES_GRANTED;
      else if (p_block) ent_st[w_idx] <= ES_BLOCKED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_valid <= '0;
      counter   <= '0;
      done      <= '0;
      pur_cnt   <= '0;
      pro_cnt   <= '0;
      exist     <= 1'b0;
      inc_all   <= 1'b0;
      inc_oth   <= 1'b0;
      fr_found  <= 1'b0;
      r1_found  <= 1'b0;
      r2_found  <= 1'b0;
      cv_found  <= 1'b0;
      w_found   <= 1'b0;
      fail      <= 1'b0;
    end else begin
      if (cmd.load) begin
        pur_cnt  <= '0;
        pro_cnt  <= '0;
        done     <= '0;
        exist    <= 1'b0;
        inc_all  <= 1'b0;
        inc_oth  <= 1'b0;
        fr_found <= 1'b0;
        r1_found <= 1'b0;
        r2_found <= 1'b0;
        cv_found <= 1'b0;
      end
      if (cmd.idx_clr) begin
        w_found <= 1'b0;
        fail    <= 1'b0;
      end
      if (cmd.main_step) begin
        if (v_i && same_q && own_i && ent_st[idx] != ES_CONVERTING) exist <= 1'b1;
        if (v_i && same_q && ent_st[idx] == ES_GRANTED && !compat(ent_mode[idx], q_mode)) begin
          inc_all <= 1'b1;
          if (!own_i) inc_oth <= 1'b1;
        end
        if (!v_i) fr_found <= 1'b1;
        if (v_i && same_q && own_i && (ent_st[idx] == ES_GRANTED ||
            ent_st[idx] == ES_CONVERTING)) r1_found <= 1'b1;
        if (v_i && same_q && own_i) r2_found <= 1'b1;
        if (v_i && same_q && own_i && ent_st[idx] == ES_GRANTED) cv_found <= 1'b1;
        if (q_kind == KIND_PURGE && v_i && own_i) begin
          ent_valid[idx] <= 1'b0;
          pur_cnt        <= pur_cnt + 1'b1;
        end
      end
      if (cmd.apply) begin
        if (q_kind == KIND_REQUEST && !inv && !exist && !(inc_all && (q_noq || q_try)) &&
            fr_found) begin
          ent_valid[fr_idx] <= 1'b1;
          counter           <= counter + 16'd1;
        end
        if (q_kind == KIND_RELEASE && rel_found) ent_valid[rel_idx] <= 1'b0;
      end
      if (cmd.sel_step && cand) w_found <= 1'b1;
      if (cmd.chk_step && hold_hit && !cmd.chk_done) fail <= 1'b1;
      if (cmd.chk_done) begin
        done[w_idx] <= 1'b1;
        if (!(fail || hold_hit)) pro_cnt <= pro_cnt + 1'b1;
      end
    end
  end

  assign res_purged   = (int'(pur_cnt) > 31) ? 5'd31 : 5'(pur_cnt);
  assign res_promoted = (int'(pro_cnt) > 31) ? 5'd31 : 5'(pro_cnt);

  a_pro_bound: assert property (@(posedge clk) disable iff (rst)
    int'(pro_cnt) <= TABLE_ENTRIES) else $error("promotion count overflow");
  a_done_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.chk_done |=> done[w_idx]) else $error("checked waiter not marked");
  a_load_clr: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> pro_cnt == '0 && pur_cnt == '0) else $error("counts not cleared");

endmodule

`default_nettype wire

>>> rtl/dlt_ctrl.sv
// ----------------------------------------------------------------------------
// dlt_ctrl
// Sequencer for lookup pass, update and waiter promotion passes.
// ----------------------------------------------------------------------------
`default_nettype none

module dlt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          res_free,
  output logic               res_load,
  output dlt_pkg::cmd_t      cmd,
  input  wire dlt_pkg::sts_t sts
);
  import dlt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    res_load   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.main_step = 1'b1;
        if (sts.idx_last) state_next = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply   = 1'b1;
        cmd.idx_clr = 1'b1;
        state_next  = sts.need_promote ? S_PSEL : S_DONE;
      end
      S_PSEL: begin
        cmd.sel_step = 1'b1;
        if (sts.idx_last) state_next = sts.sel_found ? S_PCHK : S_DONE;
      end
      S_PCHK: begin
        cmd.chk_step = 1'b1;
        if (sts.idx_last) begin
          cmd.chk_done = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_next   = S_PSEL;
        end
      end
      S_DONE: begin
        if (res_free) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_scan_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_PCHK && !sts.idx_last) |=> state == S_PCHK) else $error("check pass cut short");
  a_apply_once: assert property (@(posedge clk) disable iff (rst)
    state == S_APPLY |=> state == S_PSEL || state == S_DONE) else $error("bad apply exit");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");

endmodule

`default_nettype wire

>>> rtl/distributed_lock_table.sv
// ----------------------------------------------------------------------------
// distributed_lock_table
// Six-mode lock manager over a flat table of lock entries.
//
// Input channel (in_valid/in_ready) takes one transaction per operation:
// request, release, convert or purge of a node. Output channel
// (out_valid/out_ready) returns one transaction per operation carrying
// status, purged and promoted.
// Each operation runs one lookup pass over all TABLE_ENTRIES entries, an
// update step, then for release, downgrade and purge a promotion loop:
// per waiting entry one selection pass and one holder check pass over
// the table, plus a final selection pass. Operations are accepted one
// at a time.
// in_ready is high while the sequencer is idle. A finished result sits in
// the output register; the next operation is accepted while it waits, and
// only the hand-off of the following result stalls on out_ready.
// Reset empties the table and clears the insert counter.
// ----------------------------------------------------------------------------
`default_nettype none

module distributed_lock_table #(
  parameter int TABLE_ENTRIES = dlt_pkg::DEF_ENTRIES
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] volume,
  input  wire logic [63:0] inode,
  input  wire logic [63:0] offset,
  input  wire logic [31:0] alloc_group,
  input  wire logic [7:0]  res_type,
  input  wire logic [7:0]  node,
  input  wire logic [2:0]  mode,
  input  wire logic        noqueue,
  input  wire logic        trylock,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [4:0]       purged,
  output logic [4:0]       promoted
);
  import dlt_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic       res_load;
  logic [2:0] res_status;
  logic [4:0] res_purged, res_promoted;

  dlt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .res_free (!out_valid || out_ready),
    .res_load (res_load),
    .cmd      (cmd),
    .sts      (sts)
  );

  dlt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .kind         (kind),
    .volume       (volume),
    .inode        (inode),
    .offset       (offset),
    .alloc_group  (alloc_group),
    .res_type     (res_type),
    .node         (node),
    .mode         (mode),
    .noqueue      (noqueue),
    .trylock      (trylock),
    .res_status   (res_status),
    .res_purged   (res_purged),
    .res_promoted (res_promoted)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status   <= res_status;
      purged   <= res_purged;
      promoted <= res_promoted;
    end
  end

endmodule

`default_nettype wire
